// ----- src/maf_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants of the moving average filter.
// No dependencies; every other file but maf_div refers to it by scoped names.
package maf_pkg;

	localparam int SAMPLE_W = 16;
	localparam int CNT_W = 6;
	localparam int MAX_WINDOW = 32;
	localparam int CMDQ_DEPTH = 2;

	localparam logic OP_PUSH = 1'b0;
	localparam logic OP_CLEAR = 1'b1;

	localparam logic [CNT_W-1:0] WINDOW_RESET = 6'd16;

	typedef struct packed {
		logic operation;
		logic signed [SAMPLE_W-1:0] sample;
	} in_item_t;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] average;
		logic [CNT_W-1:0] samples_used;
	} out_item_t;

	typedef struct packed {
		logic is_clear;
		logic signed [SAMPLE_W-1:0] sample;
	} cmd_t;

endpackage

// ----- src/maf_front.sv -----
`timescale 1ns / 1ps
// Input stage: accepts an item beat, decodes it into a command and hands it to the queue.
// Depends on maf_pkg.
module maf_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	output logic             full,
	input  maf_pkg::in_item_t item,
	output logic             cmd_push,
	input  logic             cmd_full,
	output maf_pkg::cmd_t    cmd
);

	logic          valid_q;
	maf_pkg::cmd_t cmd_q;
	logic          accept;
	logic          fwd;
	maf_pkg::cmd_t decoded;

	assign full   = valid_q && cmd_full;
	assign accept = push && !full;
	assign fwd    = valid_q && !cmd_full;

	always_comb begin
		decoded.is_clear = (item.operation == maf_pkg::OP_CLEAR);
		decoded.sample   = decoded.is_clear ? '0 : item.sample;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (accept) begin
			valid_q <= 1'b1;
		end else if (fwd) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q <= decoded;
		end
	end

	assign cmd_push = valid_q;
	assign cmd      = cmd_q;

endmodule

// ----- src/maf_cmd_queue.sv -----
`timescale 1ns / 1ps
// Short command queue between the input stage and the execution stage.
// Depends on maf_pkg.
module maf_cmd_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	output logic          full,
	input  maf_pkg::cmd_t wdata,
	input  logic          pop,
	output logic          empty,
	output maf_pkg::cmd_t rdata
);

	localparam int DEPTH = maf_pkg::CMDQ_DEPTH;
	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	maf_pkg::cmd_t  slot_q [DEPTH];
	logic [PW-1:0]  wr_q;
	logic [PW-1:0]  rd_q;
	logic [CW-1:0]  cnt_q;
	logic           do_push;
	logic           do_pop;

	assign full    = (cnt_q == CW'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = slot_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + PW'(1);
			end
			if (do_pop) begin
				rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + PW'(1);
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_q] <= wdata;
		end
	end

endmodule

// ----- src/maf_div.sv -----
`timescale 1ns / 1ps
// Iterative signed-by-unsigned divider, one quotient bit per cycle, truncating toward zero.
// No package dependencies.
module maf_div #(
	parameter int DIVIDEND_W = 22,
	parameter int DIVISOR_W  = 6
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic signed [DIVIDEND_W-1:0] dividend,
	input  logic [DIVISOR_W-1:0]         divisor,
	output logic                         busy,
	output logic signed [DIVIDEND_W-1:0] quotient
);

	localparam int STEP_W = $clog2(DIVIDEND_W + 1);

	logic                  busy_q;
	logic [STEP_W-1:0]     step_q;
	logic                  neg_q;
	logic [DIVIDEND_W-1:0] num_q;
	logic [DIVIDEND_W-1:0] quo_q;
	logic [DIVISOR_W-1:0]  rem_q;
	logic [DIVISOR_W-1:0]  den_q;
	logic [DIVISOR_W:0]    trial;
	logic                  ge;
	logic [DIVISOR_W:0]    diff;

	assign trial = {rem_q, num_q[DIVIDEND_W-1]};
	assign ge    = (trial >= {1'b0, den_q});
	assign diff  = trial - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			step_q <= STEP_W'(DIVIDEND_W);
		end else if (busy_q) begin
			step_q <= step_q - STEP_W'(1);
			if (step_q == STEP_W'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			neg_q <= dividend[DIVIDEND_W-1];
			num_q <= dividend[DIVIDEND_W-1] ? -dividend : dividend;
			quo_q <= '0;
			rem_q <= '0;
			den_q <= divisor;
		end else if (busy_q) begin
			num_q <= {num_q[DIVIDEND_W-2:0], 1'b0};
			quo_q <= {quo_q[DIVIDEND_W-2:0], ge};
			rem_q <= ge ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
		end
	end

	assign busy     = busy_q;
	assign quotient = neg_q ? -signed'(quo_q) : signed'(quo_q);

endmodule

// ----- src/maf_back.sv -----
`timescale 1ns / 1ps
// Execution stage: sample ring, running sum, window bookkeeping and result register.
// Depends on maf_pkg and maf_div.
module maf_back (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          window_we,
	input  logic [maf_pkg::CNT_W-1:0]     window_wdata,
	input  logic                          cmd_empty,
	output logic                          cmd_pop,
	input  maf_pkg::cmd_t                 cmd,
	output logic                          empty,
	input  logic                          pop,
	output maf_pkg::out_item_t            result
);

	localparam int MAX_WINDOW = maf_pkg::MAX_WINDOW;
	localparam int SW = maf_pkg::SAMPLE_W;
	localparam int CW = maf_pkg::CNT_W;
	localparam int PTR_W = $clog2(MAX_WINDOW);
	localparam int SUM_W = SW + $clog2(MAX_WINDOW) + 1;

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_START = 2'd1;
	localparam logic [1:0] ST_DROP  = 2'd2;
	localparam logic [1:0] ST_WAIT  = 2'd3;

	logic [1:0]              state_q;
	logic [CW-1:0]           window_q;
	logic [PTR_W-1:0]        wp_q;
	logic [PTR_W-1:0]        oldest_q;
	logic signed [SUM_W-1:0] sum_q;
	logic [CW-1:0]           held_q;
	logic [CW-1:0]           dsr_q;
	logic                    full_q;
	logic                    clr_q;
	logic                    res_valid_q;
	maf_pkg::out_item_t      res_q;
	logic signed [SW-1:0]    ring_q [MAX_WINDOW];
	logic signed [SW-1:0]    rd_q;

	logic [CW-1:0]           win;
	logic [PTR_W-1:0]        wp_next;
	logic [PTR_W-1:0]        oldest_next;
	logic [CW-1:0]           held_inc;
	logic                    ring_we;
	logic                    ring_re;
	logic                    div_start;
	logic                    div_busy;
	logic signed [SUM_W-1:0] quotient;
	logic                    res_load;

	always_comb begin
		if (window_q == '0) begin
			win = CW'(1);
		end else if (window_q > CW'(MAX_WINDOW)) begin
			win = CW'(MAX_WINDOW);
		end else begin
			win = window_q;
		end
	end

	assign wp_next     = (CW'(wp_q) + CW'(1) >= win) ? '0 : wp_q + PTR_W'(1);
	assign oldest_next = (CW'(oldest_q) + CW'(1) >= win) ? '0 : oldest_q + PTR_W'(1);
	assign held_inc    = held_q + CW'(1);

	assign cmd_pop   = (state_q == ST_IDLE) && !cmd_empty;
	assign ring_we   = cmd_pop && !cmd.is_clear;
	assign ring_re   = (state_q == ST_START) && full_q;
	assign div_start = (state_q == ST_START);
	assign res_load  = (state_q == ST_WAIT) && !div_busy && (!res_valid_q || pop);

	maf_div #(
		.DIVIDEND_W(SUM_W),
		.DIVISOR_W (CW)
	) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.dividend(sum_q),
		.divisor (dsr_q),
		.busy    (div_busy),
		.quotient(quotient)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			window_q    <= maf_pkg::WINDOW_RESET;
			wp_q        <= PTR_W'(MAX_WINDOW - 1);
			oldest_q    <= '0;
			sum_q       <= '0;
			held_q      <= '0;
			dsr_q       <= '0;
			full_q      <= 1'b0;
			clr_q       <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (window_we) begin
				window_q <= window_wdata;
				wp_q     <= PTR_W'(MAX_WINDOW - 1);
				oldest_q <= '0;
				sum_q    <= '0;
				held_q   <= '0;
			end else begin
				unique case (state_q)
					ST_IDLE: begin
						if (cmd_pop) begin
							if (cmd.is_clear) begin
								wp_q     <= PTR_W'(MAX_WINDOW - 1);
								oldest_q <= '0;
								sum_q    <= '0;
								held_q   <= '0;
								dsr_q    <= '0;
								clr_q    <= 1'b1;
								state_q  <= ST_WAIT;
							end else begin
								wp_q    <= wp_next;
								sum_q   <= sum_q + SUM_W'(cmd.sample);
								held_q  <= held_inc;
								full_q  <= (held_inc >= win);
								dsr_q   <= (held_inc >= win) ? win : held_inc;
								clr_q   <= 1'b0;
								state_q <= ST_START;
							end
						end
					end
					ST_START: begin
						state_q <= full_q ? ST_DROP : ST_WAIT;
					end
					ST_DROP: begin
						sum_q    <= sum_q - SUM_W'(rd_q);
						oldest_q <= oldest_next;
						held_q   <= held_q - CW'(1);
						state_q  <= ST_WAIT;
					end
					ST_WAIT: begin
						if (res_load) begin
							state_q <= ST_IDLE;
						end
					end
					default: begin
						state_q <= ST_IDLE;
					end
				endcase
			end
			if (res_load) begin
				res_valid_q <= 1'b1;
			end else if (pop) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ring_we) begin
			ring_q[wp_next] <= cmd.sample;
		end
		if (ring_re) begin
			rd_q <= ring_q[oldest_q];
		end
		if (res_load) begin
			res_q.average      <= clr_q ? '0 : quotient[SW-1:0];
			res_q.samples_used <= dsr_q;
		end
	end

	assign empty  = !res_valid_q;
	assign result = res_q;

endmodule

// ----- src/moving_average_filter_top.sv -----
`timescale 1ns / 1ps
// Top level of the moving average filter over a ring of signed samples.
// Depends on maf_pkg, maf_front, maf_cmd_queue and maf_back.
//
// Input channel: an item beat is taken when push is high and full is low. Operation
// push stores the sample and answers the mean of the held samples; operation clear
// empties the window and answers zero over zero samples.
// Result channel: while empty is low the oldest result sits on result; a beat leaves
// when pop is high and empty is low. Every input beat yields exactly one result beat.
// Config: window_we writes window_wdata into the window size and empties the window;
// write only while no item is in flight.
// Path: a push passes the input stage, the queue, the sequencing states and the
// bit-serial divider, one quotient bit per sum bit; a clear skips the divider. The
// divider sets the rate: the execution stage takes no new item before the divider
// is through with the last push. Input beats keep being taken into the two-entry queue while a
// result waits; when the receiver stalls, the result register holds, the execution
// stage stops once its next result is ready, and full rises when queue and input
// stage are occupied.
// Reset: window size 16, window empty, no result pending, full low.
module moving_average_filter_top (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      push,
	output logic                      full,
	input  maf_pkg::in_item_t         item,
	output logic                      empty,
	input  logic                      pop,
	output maf_pkg::out_item_t        result,
	input  logic                      window_we,
	input  logic [maf_pkg::CNT_W-1:0] window_wdata
);

	maf_pkg::cmd_t fe_cmd;
	logic          fe_push;
	logic          q_full;
	maf_pkg::cmd_t q_cmd;
	logic          q_empty;
	logic          q_pop;

	maf_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.full    (full),
		.item    (item),
		.cmd_push(fe_push),
		.cmd_full(q_full),
		.cmd     (fe_cmd)
	);

	maf_cmd_queue u_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (fe_push),
		.full  (q_full),
		.wdata (fe_cmd),
		.pop   (q_pop),
		.empty (q_empty),
		.rdata (q_cmd)
	);

	maf_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.window_we   (window_we),
		.window_wdata(window_wdata),
		.cmd_empty   (q_empty),
		.cmd_pop     (q_pop),
		.cmd         (q_cmd),
		.empty       (empty),
		.pop         (pop),
		.result      (result)
	);

endmodule

// ----- src/maf_checker.sv -----
`timescale 1ns / 1ps
// Port-level checks of the moving average filter, bound to the top level.
// Depends on maf_pkg and moving_average_filter_top.
module maf_checker (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      push,
	input logic                      empty,
	input logic                      pop,
	input maf_pkg::out_item_t        result,
	input logic                      window_we
);

	localparam int CW = maf_pkg::CNT_W;
	localparam int MAX_WINDOW = maf_pkg::MAX_WINDOW;

	a_result_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(result)))
		else $error("stalled result beat changed or vanished");

	a_clear_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && result.samples_used == '0) |-> (result.average == '0))
		else $error("result over zero samples has nonzero average");

	a_used_bound: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (result.samples_used <= CW'(MAX_WINDOW)))
		else $error("samples_used exceeds the largest window");

	a_no_result_on_empty_cfg: assert property (@(posedge clk) disable iff (!arst_n)
		(empty && !push && window_we) |=> empty)
		else $error("result appeared from a window write alone");

endmodule

bind moving_average_filter_top maf_checker u_maf_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.push     (push),
	.empty    (empty),
	.pop      (pop),
	.result   (result),
	.window_we(window_we)
);

// ----- dv/moving_average_filter_top_test.sv -----
`timescale 1ns / 1ps
// Self-checking bench for moving_average_filter_top: directed table, then random windows.
// Predicts each result beat that has no fixed expectation with its own ring-buffer average; depends on maf_pkg.
module moving_average_filter_top_test;

	typedef enum logic {ROW_BEAT, ROW_CFG} row_kind_t;

	typedef struct {
		row_kind_t kind;
		logic [maf_pkg::CNT_W-1:0] wsize;
		maf_pkg::in_item_t beat;
		bit fixed_want;
		maf_pkg::out_item_t want;
	} row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic push = 1'b0;
	logic full;
	maf_pkg::in_item_t item = '0;
	logic empty;
	logic pop = 1'b0;
	maf_pkg::out_item_t result;
	logic window_we = 1'b0;
	logic [maf_pkg::CNT_W-1:0] window_wdata = '0;

	maf_pkg::out_item_t pending_means[$];
	row_t dir_rows[$];
	bit src_idle_on = 1'b1;
	bit sink_idle_on = 1'b1;
	int unsigned fail_cnt = 0;
	int unsigned beats_sent = 0;
	int unsigned clears_sent = 0;
	int unsigned results_seen = 0;
	int unsigned cfg_writes = 0;

	// predictor state
	logic [maf_pkg::CNT_W-1:0] window_reg;
	logic signed [maf_pkg::SAMPLE_W-1:0] ring [32];
	int unsigned wr_slot;
	int unsigned old_slot;
	int unsigned held;
	longint acc_sum;

	always #5 clk = ~clk;

	moving_average_filter_top uut (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.item(item),
		.empty(empty),
		.pop(pop),
		.result(result),
		.window_we(window_we),
		.window_wdata(window_wdata)
	);

	function automatic void note_fail(string msg);
		fail_cnt++;
		if (fail_cnt <= 10) begin
			$display("ERROR @%0t: %s", $time, msg);
		end
	endfunction

	function automatic int unsigned win_in_use();
		if (window_reg == 0) begin
			return 1;
		end
		if (window_reg > 32) begin
			return 32;
		end
		return int'(window_reg);
	endfunction

	function automatic void flush_window();
		foreach (ring[i]) ring[i] = '0;
		wr_slot = 31;
		old_slot = 0;
		acc_sum = 0;
		held = 0;
	endfunction

	function automatic maf_pkg::out_item_t next_mean(maf_pkg::in_item_t b);
		maf_pkg::out_item_t r;
		int unsigned w;
		longint q;
		w = win_in_use();
		r = '0;
		if (b.operation == maf_pkg::OP_CLEAR) begin
			flush_window();
			return r;
		end
		wr_slot = (wr_slot + 1 >= w) ? 0 : wr_slot + 1;
		ring[wr_slot] = b.sample;
		acc_sum += longint'($signed(b.sample));
		held++;
		if (held >= w) begin
			q = acc_sum / longint'(w);
			r.samples_used = w[maf_pkg::CNT_W-1:0];
			acc_sum -= longint'(ring[old_slot]);
			old_slot = (old_slot + 1 >= w) ? 0 : old_slot + 1;
			held--;
		end else begin
			q = acc_sum / longint'(held);
			r.samples_used = held[maf_pkg::CNT_W-1:0];
		end
		r.average = q[maf_pkg::SAMPLE_W-1:0];
		return r;
	endfunction

	function automatic row_t beat_row(logic op, logic [maf_pkg::SAMPLE_W-1:0] s, bit fixed,
			logic [maf_pkg::SAMPLE_W-1:0] avg, logic [maf_pkg::CNT_W-1:0] used);
		row_t r;
		r.kind = ROW_BEAT;
		r.wsize = '0;
		r.beat.operation = op;
		r.beat.sample = s;
		r.fixed_want = fixed;
		r.want.average = avg;
		r.want.samples_used = used;
		return r;
	endfunction

	function automatic row_t cfg_row(logic [maf_pkg::CNT_W-1:0] w);
		row_t r;
		r.kind = ROW_CFG;
		r.wsize = w;
		r.beat = '0;
		r.fixed_want = 1'b0;
		r.want = '0;
		return r;
	endfunction

	task automatic send_beat(input maf_pkg::in_item_t b, input bit fixed,
			input maf_pkg::out_item_t want);
		int unsigned gap;
		maf_pkg::out_item_t predicted;
		gap = src_idle_on ? $urandom_range(0, 19) : 0;
		@(negedge clk);
		if (gap != 0) begin
			push <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		push <= 1'b1;
		item <= b;
		do @(posedge clk); while (full);
		predicted = next_mean(b);
		pending_means.push_back(fixed ? want : predicted);
		beats_sent++;
		if (b.operation == maf_pkg::OP_CLEAR) begin
			clears_sent++;
		end
	endtask

	// drop push and wait until every result is out and the divider is quiet
	task automatic settle();
		@(negedge clk);
		push <= 1'b0;
		while (pending_means.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_window(input logic [maf_pkg::CNT_W-1:0] w);
		@(negedge clk);
		window_we <= 1'b1;
		window_wdata <= w;
		@(negedge clk);
		window_we <= 1'b0;
		window_reg = w;
		flush_window();
		cfg_writes++;
	endtask

	initial begin : sink
		maf_pkg::out_item_t want;
		int unsigned stall;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			stall = sink_idle_on ? $urandom_range(0, 19) : 0;
			if (stall != 0) begin
				pop <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			pop <= 1'b1;
			do @(posedge clk); while (empty);
			results_seen++;
			if (pending_means.size() == 0) begin
				note_fail($sformatf("unexpected result avg=%0d used=%0d",
					result.average, result.samples_used));
			end else begin
				want = pending_means.pop_front();
				if (result.average !== want.average) begin
					note_fail($sformatf("result %0d: average exp %0d got %0d",
						results_seen, want.average, result.average));
				end
				if (result.samples_used !== want.samples_used) begin
					note_fail($sformatf("result %0d: samples_used exp %0d got %0d",
						results_seen, want.samples_used, result.samples_used));
				end
			end
		end
	end

	initial begin : stim
		maf_pkg::in_item_t b;
		logic [maf_pkg::CNT_W-1:0] wsize;
		int unsigned n;
		int unsigned rand_goal;
		int unsigned i;

		window_reg = maf_pkg::WINDOW_RESET;
		flush_window();

		dir_rows.push_back(beat_row(maf_pkg::OP_PUSH, 16'h7FFF, 1, 16'h7FFF, 6'd1));
		dir_rows.push_back(beat_row(maf_pkg::OP_PUSH, 16'h8000, 1, 16'h0000, 6'd2));
		dir_rows.push_back(beat_row(maf_pkg::OP_CLEAR, 16'h7FFF, 1, 16'h0000, 6'd0));
		dir_rows.push_back(beat_row(maf_pkg::OP_PUSH, 16'h8000, 1, 16'h8000, 6'd1));
		dir_rows.push_back(beat_row(maf_pkg::OP_PUSH, 16'hFFFF, 1, 16'hC000, 6'd2));
		dir_rows.push_back(beat_row(maf_pkg::OP_PUSH, 16'h0000, 0, '0, '0));
		dir_rows.push_back(beat_row(maf_pkg::OP_CLEAR, 16'h8000, 1, 16'h0000, 6'd0));
		dir_rows.push_back(cfg_row(6'd1));
		dir_rows.push_back(beat_row(maf_pkg::OP_PUSH, 16'h3039, 1, 16'h3039, 6'd1));
		dir_rows.push_back(beat_row(maf_pkg::OP_PUSH, 16'hFFF9, 1, 16'hFFF9, 6'd1));
		dir_rows.push_back(beat_row(maf_pkg::OP_CLEAR, 16'h5A5A, 1, 16'h0000, 6'd0));
		dir_rows.push_back(cfg_row(6'd0));
		dir_rows.push_back(beat_row(maf_pkg::OP_PUSH, 16'h8000, 1, 16'h8000, 6'd1));
		dir_rows.push_back(beat_row(maf_pkg::OP_PUSH, 16'h7FFF, 1, 16'h7FFF, 6'd1));
		dir_rows.push_back(cfg_row(6'd63));
		dir_rows.push_back(beat_row(maf_pkg::OP_PUSH, 16'h7FFF, 1, 16'h7FFF, 6'd1));
		dir_rows.push_back(beat_row(maf_pkg::OP_PUSH, 16'h1234, 0, '0, '0));
		dir_rows.push_back(beat_row(maf_pkg::OP_PUSH, 16'h8000, 0, '0, '0));
		dir_rows.push_back(cfg_row(6'd2));
		dir_rows.push_back(beat_row(maf_pkg::OP_PUSH, 16'h7FFF, 1, 16'h7FFF, 6'd1));
		dir_rows.push_back(beat_row(maf_pkg::OP_PUSH, 16'h7FFF, 1, 16'h7FFF, 6'd2));
		dir_rows.push_back(beat_row(maf_pkg::OP_PUSH, 16'h8000, 0, '0, '0));
		dir_rows.push_back(beat_row(maf_pkg::OP_PUSH, 16'h8000, 0, '0, '0));
		dir_rows.push_back(beat_row(maf_pkg::OP_PUSH, 16'h8000, 0, '0, '0));
		dir_rows.push_back(cfg_row(6'd32));
		dir_rows.push_back(beat_row(maf_pkg::OP_PUSH, 16'h5555, 0, '0, '0));
		dir_rows.push_back(beat_row(maf_pkg::OP_PUSH, 16'hAAAA, 0, '0, '0));
		dir_rows.push_back(beat_row(maf_pkg::OP_CLEAR, 16'h0000, 1, 16'h0000, 6'd0));

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (dir_rows[k]) begin
			if (dir_rows[k].kind == ROW_CFG) begin
				settle();
				write_window(dir_rows[k].wsize);
			end else begin
				send_beat(dir_rows[k].beat, dir_rows[k].fixed_want, dir_rows[k].want);
			end
		end

		rand_goal = 700;
		while (beats_sent < rand_goal) begin
			case ($urandom_range(0, 9))
				0: wsize = 6'd0;
				1: wsize = 6'($urandom_range(33, 63));
				2: wsize = 6'd32;
				3: wsize = 6'd1;
				default: wsize = 6'($urandom_range(2, 31));
			endcase
			settle();
			write_window(wsize);
			src_idle_on = ($urandom_range(0, 2) != 0);
			sink_idle_on = ($urandom_range(0, 2) != 0);
			n = $urandom_range(8, 80);
			for (i = 0; i < n && beats_sent < rand_goal; i++) begin
				b.operation = ($urandom_range(0, 24) == 0) ? maf_pkg::OP_CLEAR
					: maf_pkg::OP_PUSH;
				case ($urandom_range(0, 9))
					0: b.sample = 16'h7FFF;
					1: b.sample = 16'h8000;
					2: b.sample = 16'($urandom_range(0, 15)) - 16'd8;
					default: b.sample = 16'($urandom);
				endcase
				send_beat(b, 1'b0, '0);
			end
		end

		@(negedge clk);
		push <= 1'b0;
		for (i = 0; i < 20000 && pending_means.size() != 0; i++) @(posedge clk);
		repeat (40) @(posedge clk);
		if (pending_means.size() != 0) begin
			note_fail($sformatf("%0d results never arrived", pending_means.size()));
		end

		$display("Run covered %0d beats (%0d clears) over %0d window settings",
			beats_sent, clears_sent, cfg_writes);
		$display("with random gaps and stalls; %0d results checked, %0d errors",
			results_seen, fail_cnt);
		if (fail_cnt == 0) begin
			$display("** moving_average_filter_top: PASSED **");
		end else begin
			$display("** moving_average_filter_top: FAILED **");
		end
		$finish;
	end

	initial begin : watchdog
		#4_000_000;
		$display("Timeout: %0d beats sent, %0d results outstanding",
			beats_sent, pending_means.size());
		$display("** moving_average_filter_top: FAILED **");
		$finish;
	end

endmodule
